@@ rtl/gww_pkg.sv @@
// ----------------------------------------------------------------------------
// gww_pkg: shared types and constants for the greedy word-wrap stream
// Character codes, the paragraph threshold, the line width reset value,
// the sequencer state type and a whitespace test.
// ----------------------------------------------------------------------------
package gww_pkg;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  // newlines between words that make a paragraph break
  localparam logic [1:0] PARA_RUN = 2'd2;

  localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARA1,
    S_PARA2,
    S_PRE,
    S_WORD,
    S_POST
  } state_t;

  function automatic logic is_white(input logic [7:0] b);
    return b inside {CH_SP, [CH_TAB:CH_CR]};
  endfunction

endpackage

@@ rtl/greedy_word_wrap_stream_top.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream_top: greedy word wrap of a byte stream
// Collects words in a small store and refills them to cfg line width.
// ----------------------------------------------------------------------------
// A word byte is taken and causes no output, except the first word byte
// after two or more newlines, which sends two newlines. A whitespace or
// end-of-text item that closes a pending word sends its bytes, preceded by
// a space or newline when a word is already on the line and followed by a
// trailing newline at end of text or after an overlong word. The single
// output register and the one read port of the word store give one byte
// per cycle while out_stall is low. A new item is taken as soon as the
// last byte of the previous run sits in the output register. A word byte
// arriving with the store full is dropped and the sticky overlong flag is
// set; a word wider than line_width goes on a line of its own and sets it
// too. No clearing pass: only bytes of the current word are ever read back.
// ----------------------------------------------------------------------------
module greedy_word_wrap_stream_top
  import gww_pkg::*;
#(
  parameter int MAX_WORD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // input items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_overlong_error,
  // line width register
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_line_width
);

  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CW = $clog2(MAX_WORD + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORD);

  // line state
  state_t        state_r, state_nxt;
  logic [CW-1:0] word_count_r;
  logic [8:0]    line_used_r;
  logic          not_first_r;
  logic [1:0]    newline_run_r;
  logic          error_r;
  logic [7:0]    line_width_r;

  // run plan captured when a word is closed
  logic [7:0]    pre_byte_r;
  logic          post_r;
  logic [CW-1:0] len_r;
  logic [AW-1:0] idx_r;

  // output register
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_err_r;

  logic          in_accept;
  logic          byte_white;
  logic          do_flush;
  logic          do_word;
  logic          do_para;
  logic [9:0]    wl10;
  logic [9:0]    total10;
  logic [9:0]    width10;
  logic          fit_line;
  logic          over_wl;
  logic [8:0]    flush_used;
  logic          load_ok;
  logic          word_last;

  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;

  // ---- decisions on the accepted item ----
  assign byte_white = is_white(in_byte);
  assign do_flush   = in_accept && (in_end_of_text || byte_white) && (word_count_r != '0);
  assign do_word    = in_accept && !in_end_of_text && !byte_white;
  assign do_para    = do_word && (newline_run_r >= PARA_RUN);
  assign wr_en      = do_word && (word_count_r < MAX_CNT);

  assign wl10     = 10'(word_count_r);
  assign width10  = 10'(line_width_r);
  assign total10  = 10'(line_used_r) + wl10 + 10'd1;
  assign fit_line = (total10 <= width10);
  assign over_wl  = (wl10 > width10);
  // word after a space keeps the line; otherwise the word starts one,
  // and an overlong word leaves an empty line behind it
  assign flush_used = (not_first_r && fit_line) ? total10[8:0]
                    : (over_wl ? 9'd0 : 9'(word_count_r));

  assign word_last = ((CW'(idx_r) + CW'(1)) == len_r);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_write_en) begin
      line_width_r <= cfg_line_width;
    end
  end

  // ---- line state update ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r  <= '0;
      line_used_r   <= '0;
      not_first_r   <= 1'b0;
      newline_run_r <= '0;
      error_r       <= 1'b0;
    end else if (in_accept) begin
      if (in_end_of_text) begin
        if (do_flush && over_wl) begin
          error_r <= 1'b1;
        end
        word_count_r  <= '0;
        line_used_r   <= '0;
        not_first_r   <= 1'b0;
        newline_run_r <= '0;
      end else if (byte_white) begin
        if (do_flush) begin
          word_count_r <= '0;
          line_used_r  <= flush_used;
          not_first_r  <= !over_wl;
          if (over_wl) begin
            error_r <= 1'b1;
          end
        end
        if (in_byte == CH_NL && newline_run_r < PARA_RUN) begin
          newline_run_r <= newline_run_r + 2'd1;
        end
      end else begin
        if (do_para) begin
          not_first_r <= 1'b0;
          line_used_r <= '0;
        end
        newline_run_r <= '0;
        if (word_count_r < MAX_CNT) begin
          word_count_r <= word_count_r + CW'(1);
        end else begin
          error_r <= 1'b1;
        end
      end
    end
  end

  // ---- run plan and word index ----
  always_ff @(posedge clk) begin
    if (do_flush) begin
      pre_byte_r <= fit_line ? CH_SP : CH_NL;
      post_r     <= over_wl || in_end_of_text;
      len_r      <= word_count_r;
      idx_r      <= '0;
    end else if (state_r == S_WORD && load_ok && !word_last) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (do_para) begin
          state_nxt = S_PARA1;
        end else if (do_flush) begin
          state_nxt = not_first_r ? S_PRE : S_WORD;
        end
      end
      S_PARA1: if (load_ok) state_nxt = S_PARA2;
      S_PARA2: if (load_ok) state_nxt = S_IDLE;
      S_PRE:   if (load_ok) state_nxt = S_WORD;
      S_WORD: begin
        if (load_ok && word_last) begin
          state_nxt = post_r ? S_POST : S_IDLE;
        end
      end
      S_POST:  if (load_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // emitted byte per state; the store is read one byte ahead so its data
  // is ready when the word starts, and it holds while the output stalls
  always_comb begin
    emit      = 1'b0;
    emit_byte = CH_NL;
    emit_last = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (state_r)
      S_IDLE: begin
        rd_en = 1'b1;
      end
      S_PARA1: begin
        emit = load_ok;
      end
      S_PARA2: begin
        emit      = load_ok;
        emit_last = 1'b1;
      end
      S_PRE: begin
        emit      = load_ok;
        emit_byte = pre_byte_r;
      end
      S_WORD: begin
        emit      = load_ok;
        emit_byte = rd_data;
        emit_last = word_last && !post_r;
        rd_en     = load_ok && !word_last;
        rd_addr   = idx_r + AW'(1);
      end
      S_POST: begin
        emit      = load_ok;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  gww_word_mem #(
    .DEPTH (MAX_WORD),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (word_count_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_err_r  <= error_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last_of_run    = out_last_r;
  assign out_overlong_error = out_err_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_count_r <= MAX_CNT)
    else $error("word count past store depth");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRE || state_r == S_WORD) |-> (len_r != '0 && CW'(idx_r) < len_r))
    else $error("word run with bad length or index");

  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_end_of_text) |=>
      (word_count_r == '0 && line_used_r == '0 && newline_run_r == '0 && !not_first_r))
    else $error("line state not cleared at end of text");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !line_used_r[8] && newline_run_r <= PARA_RUN)
    else $error("line use or newline run out of range");

endmodule

@@ rtl/gww_word_mem.sv @@
// ----------------------------------------------------------------------------
// gww_word_mem: word byte store
// One write port, one read port, registered read data that holds when the
// read enable is low.
// ----------------------------------------------------------------------------
module gww_word_mem
  import gww_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // a space never reaches the store, so an unexpected one marks a bad read
  assign rd_data = is_white(rd_data_r) ? CH_SP : rd_data_r;

endmodule
